// ===== sv/vrm_pkg.sv =====
`default_nettype none

package vrm_pkg;

    // packed widths of the stream words
    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 24;

    // input word field offsets, lowest bit of each field
    localparam int VX_LSB = 0;
    localparam int VY_LSB = 6;
    localparam int VZ_LSB = 12;
    localparam int SOLID_BIT = 18;
    localparam int SX_LSB = 19;
    localparam int SY_LSB = 43;
    localparam int SZ_LSB = 67;
    localparam int DX_LSB = 91;
    localparam int DY_LSB = 107;
    localparam int DZ_LSB = 123;
    localparam int MAXD_LSB = 139;

    localparam int VOX_W = 6;
    localparam int START_W = 24;
    localparam int DIR_W = 16;
    localparam int MAXD_W = 7;
    localparam int STEP_W = MAXD_W + 1;

    // ray position: start plus up to 255 steps fits in 26 signed bits
    localparam int POS_W = 26;
    localparam int FRAC_W = 8;
    localparam int RC_W = POS_W - FRAC_W - 1;
    localparam logic signed [POS_W-1:0] HALF = POS_W'(128);

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic            neg;
        logic [RC_W-1:0] c;
    } rnd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_MOD,
        ST_CAST,
        ST_CAST_LAST,
        ST_FINISH
    } state_t;

    // floor(p + 0.5) in 8-fraction-bit fixed point
    function automatic rnd_t round_coord(input pos_t p);
        pos_t q;
        rnd_t r;
        q = p + HALF;
        r.neg = q[POS_W-1];
        r.c = q[POS_W-2:FRAC_W];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/voxel_ray_march.sv =====
// channel  dir  signals                      word contents
// -------  ---  ---------------------------  ------------------------------------------
// s_*      in   s_tvalid s_tready s_tdata    voxel write (tuser 0) or ray cast (tuser 1)
//                s_tuser
// m_*      out  m_tvalid m_tready m_tdata    one result per cast: hit flag and voxel
//                m_tuser
//
// voxel write: accepted, then read-modify-write of one grid row; a write outside the grid
//   is accepted and dropped
// ray cast: ends early on a hit; one row read of the occupancy memory per step sets the
//   pace; a zero direction or distance goes straight to the result
// after reset a clearing pass writes 2^(YW+ZW) rows with input held off
// a result waiting on m_tready does not block writes; a cast waits at its end for it
`default_nettype none

module voxel_ray_march #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64,
    parameter int GRID_Z = 64
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // voxel_x, voxel_y, voxel_z, solid, start_x, start_y, start_z,
    // dir_x, dir_y, dir_z, max_distance, zero fill
    input  wire  [vrm_pkg::S_DATA_W-1:0]          s_tdata,
    // mode
    input  wire                                  s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // hit_x, hit_y, hit_z, zero fill
    output logic [vrm_pkg::M_DATA_W-1:0]          m_tdata,
    // hit
    output logic                                 m_tuser
);

    localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int AW = YW + ZW;
    localparam int ROWS = 1 << AW;
    localparam int WC_W = 16;
    localparam logic [vrm_pkg::RC_W-1:0] GX_C = vrm_pkg::RC_W'(GRID_X);
    localparam logic [vrm_pkg::RC_W-1:0] GY_C = vrm_pkg::RC_W'(GRID_Y);
    localparam logic [vrm_pkg::RC_W-1:0] GZ_C = vrm_pkg::RC_W'(GRID_Z);
    localparam logic [WC_W-1:0] GXW_C = WC_W'(GRID_X);
    localparam logic [WC_W-1:0] GYW_C = WC_W'(GRID_Y);
    localparam logic [WC_W-1:0] GZW_C = WC_W'(GRID_Z);

    // occupancy memory: one row of x bits per (y, z)
    logic [GRID_X-1:0] mem [ROWS];
    logic [GRID_X-1:0] rd_row_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [GRID_X-1:0] mem_wdata;
    logic [GRID_X-1:0] mod_row;

    vrm_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [XW-1:0] wr_xi_reg, wr_xi_next;
    logic          wr_solid_reg, wr_solid_next;

    vrm_pkg::pos_t pos_x_reg, pos_x_next;
    vrm_pkg::pos_t pos_y_reg, pos_y_next;
    vrm_pkg::pos_t pos_z_reg, pos_z_next;
    vrm_pkg::pos_t dir_x_reg, dir_x_next;
    vrm_pkg::pos_t dir_y_reg, dir_y_next;
    vrm_pkg::pos_t dir_z_reg, dir_z_next;
    logic [vrm_pkg::STEP_W-1:0] left_reg, left_next;

    logic          chk_valid_reg, chk_valid_next;
    logic [XW-1:0] chk_xi_reg, chk_xi_next;
    logic [vrm_pkg::VOX_W-1:0] chk_hx_reg, chk_hx_next;
    logic [vrm_pkg::VOX_W-1:0] chk_hy_reg, chk_hy_next;
    logic [vrm_pkg::VOX_W-1:0] chk_hz_reg, chk_hz_next;

    logic          res_hit_reg, res_hit_next;
    logic [vrm_pkg::VOX_W-1:0] res_x_reg, res_x_next;
    logic [vrm_pkg::VOX_W-1:0] res_y_reg, res_y_next;
    logic [vrm_pkg::VOX_W-1:0] res_z_reg, res_z_next;

    logic          m_valid_reg, m_valid_next;
    logic          m_hit_reg, m_hit_next;
    logic [vrm_pkg::VOX_W-1:0] m_x_reg, m_x_next;
    logic [vrm_pkg::VOX_W-1:0] m_y_reg, m_y_next;
    logic [vrm_pkg::VOX_W-1:0] m_z_reg, m_z_next;

    // input word fields
    logic [vrm_pkg::VOX_W-1:0]   in_vx, in_vy, in_vz;
    logic                        in_solid;
    logic [vrm_pkg::START_W-1:0] in_sx, in_sy, in_sz;
    logic [vrm_pkg::DIR_W-1:0]   in_dx, in_dy, in_dz;
    logic [vrm_pkg::MAXD_W-1:0]  in_maxd;
    logic [WC_W-1:0]             wx_w, wy_w, wz_w;
    logic                        wr_in;
    logic [AW-1:0]               wr_in_addr;
    vrm_pkg::pos_t               sx_e, sy_e, sz_e, dx_e, dy_e, dz_e;

    // current step
    vrm_pkg::rnd_t rx, ry, rz;
    logic          step_in;
    logic [AW-1:0] cast_addr;
    logic          hit_now;
    logic          out_free;

    // field unpacking
    assign in_vx    = s_tdata[vrm_pkg::VX_LSB +: vrm_pkg::VOX_W];
    assign in_vy    = s_tdata[vrm_pkg::VY_LSB +: vrm_pkg::VOX_W];
    assign in_vz    = s_tdata[vrm_pkg::VZ_LSB +: vrm_pkg::VOX_W];
    assign in_solid = s_tdata[vrm_pkg::SOLID_BIT];
    assign in_sx    = s_tdata[vrm_pkg::SX_LSB +: vrm_pkg::START_W];
    assign in_sy    = s_tdata[vrm_pkg::SY_LSB +: vrm_pkg::START_W];
    assign in_sz    = s_tdata[vrm_pkg::SZ_LSB +: vrm_pkg::START_W];
    assign in_dx    = s_tdata[vrm_pkg::DX_LSB +: vrm_pkg::DIR_W];
    assign in_dy    = s_tdata[vrm_pkg::DY_LSB +: vrm_pkg::DIR_W];
    assign in_dz    = s_tdata[vrm_pkg::DZ_LSB +: vrm_pkg::DIR_W];
    assign in_maxd  = s_tdata[vrm_pkg::MAXD_LSB +: vrm_pkg::MAXD_W];

    // sign extension to position width
    assign sx_e = {{(vrm_pkg::POS_W-vrm_pkg::START_W){in_sx[vrm_pkg::START_W-1]}}, in_sx};
    assign sy_e = {{(vrm_pkg::POS_W-vrm_pkg::START_W){in_sy[vrm_pkg::START_W-1]}}, in_sy};
    assign sz_e = {{(vrm_pkg::POS_W-vrm_pkg::START_W){in_sz[vrm_pkg::START_W-1]}}, in_sz};
    assign dx_e = {{(vrm_pkg::POS_W-vrm_pkg::DIR_W){in_dx[vrm_pkg::DIR_W-1]}}, in_dx};
    assign dy_e = {{(vrm_pkg::POS_W-vrm_pkg::DIR_W){in_dy[vrm_pkg::DIR_W-1]}}, in_dy};
    assign dz_e = {{(vrm_pkg::POS_W-vrm_pkg::DIR_W){in_dz[vrm_pkg::DIR_W-1]}}, in_dz};

    // write target and its grid check
    assign wx_w = {{(WC_W-vrm_pkg::VOX_W){1'b0}}, in_vx};
    assign wy_w = {{(WC_W-vrm_pkg::VOX_W){1'b0}}, in_vy};
    assign wz_w = {{(WC_W-vrm_pkg::VOX_W){1'b0}}, in_vz};
    assign wr_in = (wx_w < GXW_C) && (wy_w < GYW_C) && (wz_w < GZW_C);
    assign wr_in_addr = {wz_w[ZW-1:0], wy_w[YW-1:0]};

    // rounding and grid check of the current ray position
    assign rx = vrm_pkg::round_coord(pos_x_reg);
    assign ry = vrm_pkg::round_coord(pos_y_reg);
    assign rz = vrm_pkg::round_coord(pos_z_reg);
    assign step_in = !rx.neg && (rx.c < GX_C) && !ry.neg && (ry.c < GY_C)
                     && !rz.neg && (rz.c < GZ_C);
    assign cast_addr = {rz.c[ZW-1:0], ry.c[YW-1:0]};

    // occupancy check of the row read in the previous cycle
    assign hit_now = chk_valid_reg && rd_row_reg[chk_xi_reg];

    assign out_free = !m_valid_reg || m_tready;

    // memory ports
    assign rd_addr = (state_reg == vrm_pkg::ST_IDLE) ? wr_in_addr : cast_addr;

    always_comb
    begin
        mod_row = rd_row_reg;
        mod_row[wr_xi_reg] = wr_solid_reg;
    end

    assign mem_we    = (state_reg == vrm_pkg::ST_CLEAR) || (state_reg == vrm_pkg::ST_WR_MOD);
    assign mem_waddr = (state_reg == vrm_pkg::ST_CLEAR) ? clr_reg : wr_addr_reg;
    assign mem_wdata = (state_reg == vrm_pkg::ST_CLEAR) ? '0 : mod_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_row_reg <= mem[rd_addr];
    end

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wr_addr_next   = wr_addr_reg;
        wr_xi_next     = wr_xi_reg;
        wr_solid_next  = wr_solid_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        dir_x_next     = dir_x_reg;
        dir_y_next     = dir_y_reg;
        dir_z_next     = dir_z_reg;
        left_next      = left_reg;
        chk_valid_next = chk_valid_reg;
        chk_xi_next    = chk_xi_reg;
        chk_hx_next    = chk_hx_reg;
        chk_hy_next    = chk_hy_reg;
        chk_hz_next    = chk_hz_reg;
        res_hit_next   = res_hit_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_z_next     = res_z_reg;
        m_valid_next   = m_valid_reg;
        m_hit_next     = m_hit_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_z_next       = m_z_reg;
        s_tready       = 1'b0;

        // output word taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            vrm_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = vrm_pkg::ST_IDLE;
                end
            end

            vrm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!s_tuser)
                    begin
                        // voxel write: row read is issued this cycle
                        wr_addr_next  = wr_in_addr;
                        wr_xi_next    = wx_w[XW-1:0];
                        wr_solid_next = in_solid;
                        if (wr_in)
                        begin
                            state_next = vrm_pkg::ST_WR_MOD;
                        end
                    end
                    else
                    begin
                        // ray cast: position loaded at step one
                        pos_x_next     = sx_e + dx_e;
                        pos_y_next     = sy_e + dy_e;
                        pos_z_next     = sz_e + dz_e;
                        dir_x_next     = dx_e;
                        dir_y_next     = dy_e;
                        dir_z_next     = dz_e;
                        left_next      = {in_maxd, 1'b0};
                        chk_valid_next = 1'b0;
                        res_hit_next   = 1'b0;
                        res_x_next     = '0;
                        res_y_next     = '0;
                        res_z_next     = '0;
                        if ((in_maxd == '0) || ((in_dx == '0) && (in_dy == '0) && (in_dz == '0)))
                        begin
                            state_next = vrm_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = vrm_pkg::ST_CAST;
                        end
                    end
                end
            end

            vrm_pkg::ST_WR_MOD:
            begin
                state_next = vrm_pkg::ST_IDLE;
            end

            vrm_pkg::ST_CAST:
            begin
                if (hit_now)
                begin
                    res_hit_next   = 1'b1;
                    res_x_next     = chk_hx_reg;
                    res_y_next     = chk_hy_reg;
                    res_z_next     = chk_hz_reg;
                    chk_valid_next = 1'b0;
                    state_next     = vrm_pkg::ST_FINISH;
                end
                else
                begin
                    chk_valid_next = step_in;
                    chk_xi_next    = rx.c[XW-1:0];
                    chk_hx_next    = rx.c[vrm_pkg::VOX_W-1:0];
                    chk_hy_next    = ry.c[vrm_pkg::VOX_W-1:0];
                    chk_hz_next    = rz.c[vrm_pkg::VOX_W-1:0];
                    pos_x_next     = pos_x_reg + dir_x_reg;
                    pos_y_next     = pos_y_reg + dir_y_reg;
                    pos_z_next     = pos_z_reg + dir_z_reg;
                    left_next      = left_reg - 1'b1;
                    if (left_reg == vrm_pkg::STEP_W'(1))
                    begin
                        state_next = vrm_pkg::ST_CAST_LAST;
                    end
                end
            end

            vrm_pkg::ST_CAST_LAST:
            begin
                if (hit_now)
                begin
                    res_hit_next = 1'b1;
                    res_x_next   = chk_hx_reg;
                    res_y_next   = chk_hy_reg;
                    res_z_next   = chk_hz_reg;
                end
                chk_valid_next = 1'b0;
                state_next     = vrm_pkg::ST_FINISH;
            end

            vrm_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_x_next     = res_x_reg;
                    m_y_next     = res_y_reg;
                    m_z_next     = res_z_reg;
                    state_next   = vrm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vrm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vrm_pkg::ST_CLEAR;
            clr_reg       <= '0;
            left_reg      <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            left_reg      <= left_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= wr_addr_next;
        wr_xi_reg    <= wr_xi_next;
        wr_solid_reg <= wr_solid_next;
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        pos_z_reg    <= pos_z_next;
        dir_x_reg    <= dir_x_next;
        dir_y_reg    <= dir_y_next;
        dir_z_reg    <= dir_z_next;
        chk_xi_reg   <= chk_xi_next;
        chk_hx_reg   <= chk_hx_next;
        chk_hy_reg   <= chk_hy_next;
        chk_hz_reg   <= chk_hz_next;
        res_hit_reg  <= res_hit_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_z_reg    <= res_z_next;
        m_hit_reg    <= m_hit_next;
        m_x_reg      <= m_x_next;
        m_y_reg      <= m_y_next;
        m_z_reg      <= m_z_next;
    end

    // output word
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {{(vrm_pkg::M_DATA_W-3*vrm_pkg::VOX_W){1'b0}}, m_z_reg, m_y_reg, m_x_reg};

`ifndef SYNTHESIS
    // a voxel write changes at most one bit of its row
    a_one_bit_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vrm_pkg::ST_WR_MOD) |-> ($countones(mem_wdata ^ rd_row_reg) <= 1))
        else $error("voxel write touched more than one bit of a row");

    // a pending occupancy check always points inside the grid along x
    a_chk_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (chk_xi_reg < GRID_X))
        else $error("occupancy check outside grid");

    // a new result word only comes from the end of a cast
    a_out_from_cast: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == vrm_pkg::ST_FINISH))
        else $error("result word without a finished cast");

    // no traffic while the clearing pass runs
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vrm_pkg::ST_CLEAR) |-> (!s_tready && !m_tvalid))
        else $error("stream activity during clearing pass");
`endif

endmodule

`default_nettype wire
